// ===== design/obb_pkg.sv =====
// obb_pkg: shared constants, types and trig helpers for the oriented box checker
// depends on nothing
`default_nettype none
package obb_pkg;
   localparam int ObstacleSlots = 32;
   localparam int SlotBits = $clog2(ObstacleSlots);
   localparam int CountBits = $clog2(ObstacleSlots + 1);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_CLEARED = 2'd0;
   localparam logic [1:0] ST_STORED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_QUERY = 2'd3;

   localparam logic [2:0] CSR_LENGTH = 3'd0;
   localparam logic [2:0] CSR_WIDTH = 3'd1;
   localparam logic [2:0] CSR_MARGIN = 3'd2;
   localparam logic [2:0] CSR_MAP_W = 3'd3;
   localparam logic [2:0] CSR_MAP_H = 3'd4;

   // corner coordinates at 2^-25 m, projections on Q1.14 axes
   typedef logic signed [41:0] coord_type;
   typedef logic signed [57:0] proj_type;
   typedef logic signed [15:0] trig_type;

   // rectangle as seen by the cells
   typedef struct packed {
      coord_type [3:0] cx;
      coord_type [3:0] cy;
      coord_type mnx, mny, mxx, mxy;
      trig_type s, c;
   } box_type;

   function automatic logic [14:0] quarter_sine(input logic [5:0] i);
      case (i)
         6'd0: quarter_sine = 15'd0;      6'd1: quarter_sine = 15'd804;
         6'd2: quarter_sine = 15'd1606;   6'd3: quarter_sine = 15'd2404;
         6'd4: quarter_sine = 15'd3196;   6'd5: quarter_sine = 15'd3981;
         6'd6: quarter_sine = 15'd4756;   6'd7: quarter_sine = 15'd5520;
         6'd8: quarter_sine = 15'd6270;   6'd9: quarter_sine = 15'd7005;
         6'd10: quarter_sine = 15'd7723;  6'd11: quarter_sine = 15'd8423;
         6'd12: quarter_sine = 15'd9102;  6'd13: quarter_sine = 15'd9760;
         6'd14: quarter_sine = 15'd10394; 6'd15: quarter_sine = 15'd11003;
         6'd16: quarter_sine = 15'd11585; 6'd17: quarter_sine = 15'd12140;
         6'd18: quarter_sine = 15'd12665; 6'd19: quarter_sine = 15'd13160;
         6'd20: quarter_sine = 15'd13623; 6'd21: quarter_sine = 15'd14053;
         6'd22: quarter_sine = 15'd14449; 6'd23: quarter_sine = 15'd14811;
         6'd24: quarter_sine = 15'd15137; 6'd25: quarter_sine = 15'd15426;
         6'd26: quarter_sine = 15'd15679; 6'd27: quarter_sine = 15'd15893;
         6'd28: quarter_sine = 15'd16069; 6'd29: quarter_sine = 15'd16207;
         6'd30: quarter_sine = 15'd16305; 6'd31: quarter_sine = 15'd16364;
         default: quarter_sine = 15'd16384;
      endcase
   endfunction

   // interpolated quarter-wave sine, argument 0..16384
   function automatic logic [14:0] qsin(input logic [14:0] p);
      logic [14:0] lo, hi;
      logic [23:0] prod;
      if (p[14]) begin
         qsin = 15'd16384;
      end else begin
         lo = quarter_sine({1'b0, p[13:9]});
         hi = quarter_sine({1'b0, p[13:9]} + 6'd1);
         prod = 24'(hi - lo) * 24'(p[8:0]) + 24'd256;
         qsin = lo + 15'(prod >> 9);
      end
   endfunction

   function automatic trig_type bsin(input logic [15:0] h);
      logic [14:0] p, m;
      p = {1'b0, h[13:0]};
      m = 15'd16384 - p;
      case (h[15:14])
         2'd0: bsin = trig_type'({1'b0, qsin(p)});
         2'd1: bsin = trig_type'({1'b0, qsin(m)});
         2'd2: bsin = -trig_type'({1'b0, qsin(p)});
         default: bsin = -trig_type'({1'b0, qsin(m)});
      endcase
   endfunction
endpackage
`default_nettype wire

// ===== design/obb_ram.sv =====
// obb_ram: generic simple dual-port ram (one write port, one read port) with registered read
// depends on nothing
`default_nettype none
module obb_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/obb_box_cell.sv =====
// obb_box_cell: builds one rectangle from a pose through registered steps
// depends on obb_pkg
`default_nettype none
module obb_box_cell
   import obb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        go,
   input  wire logic [23:0] pos_x,
   input  wire logic [23:0] pos_y,
   input  wire logic [15:0] yaw,
   input  wire logic [16:0] half_len,
   input  wire logic [16:0] half_wid,
   output box_type          box
);
   // step 1: trig lookup
   trig_type s_ff, c_ff;
   logic signed [23:0] px_ff, py_ff;
   // step 2: products
   logic signed [33:0] hlc_ff, hls_ff, hwc_ff, hws_ff;
   logic signed [23:0] px2_ff, py2_ff;
   trig_type s2_ff, c2_ff;
   box_type box_in;
   coord_type bx, by;

   always_ff @(posedge clock) begin
      if (go) begin
         s_ff <= bsin(yaw);
         c_ff <= bsin(yaw + 16'd16384);
         px_ff <= pos_x;
         py_ff <= pos_y;
      end
      hlc_ff <= $signed({1'b0, half_len}) * c_ff;
      hls_ff <= $signed({1'b0, half_len}) * s_ff;
      hwc_ff <= $signed({1'b0, half_wid}) * c_ff;
      hws_ff <= $signed({1'b0, half_wid}) * s_ff;
      px2_ff <= px_ff;
      py2_ff <= py_ff;
      s2_ff <= s_ff;
      c2_ff <= c_ff;
      box <= box_in;
   end

   // step 3: corners and bounds
   always_comb begin
      bx = coord_type'(px2_ff) <<< 15;
      by = coord_type'(py2_ff) <<< 15;
      box_in.cx[0] = bx + coord_type'(hlc_ff) - coord_type'(hws_ff);
      box_in.cy[0] = by + coord_type'(hls_ff) + coord_type'(hwc_ff);
      box_in.cx[1] = bx + coord_type'(hlc_ff) + coord_type'(hws_ff);
      box_in.cy[1] = by + coord_type'(hls_ff) - coord_type'(hwc_ff);
      box_in.cx[2] = bx - coord_type'(hlc_ff) + coord_type'(hws_ff);
      box_in.cy[2] = by - coord_type'(hls_ff) - coord_type'(hwc_ff);
      box_in.cx[3] = bx - coord_type'(hlc_ff) - coord_type'(hws_ff);
      box_in.cy[3] = by - coord_type'(hls_ff) + coord_type'(hwc_ff);
      box_in.mnx = box_in.cx[0]; box_in.mxx = box_in.cx[0];
      box_in.mny = box_in.cy[0]; box_in.mxy = box_in.cy[0];
      for (int i = 1; i < 4; i++) begin
         if (box_in.cx[i] < box_in.mnx) box_in.mnx = box_in.cx[i];
         if (box_in.cx[i] > box_in.mxx) box_in.mxx = box_in.cx[i];
         if (box_in.cy[i] < box_in.mny) box_in.mny = box_in.cy[i];
         if (box_in.cy[i] > box_in.mxy) box_in.mxy = box_in.cy[i];
      end
      box_in.s = s2_ff;
      box_in.c = c2_ff;
   end
endmodule
`default_nettype wire

// ===== design/obb_axis_cell.sv =====
// obb_axis_cell: one separating-axis cell of the chain, projects both boxes on its axis
// depends on obb_pkg
`default_nettype none
module obb_axis_cell
   import obb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     valid_in,
   input  wire logic     hit_in,
   input  wire box_type  me,
   input  wire box_type  ob_in,
   input  wire trig_type ux,
   input  wire trig_type uy,
   output logic          valid_out,
   output logic          hit_out,
   output box_type       ob_out
);
   // stage a: corner products, stage b: sums and extremes
   proj_type ax_ff [8], ay_ff [8];
   logic va_ff, ha_ff;
   box_type ob_a_ff;
   proj_type p [8];
   proj_type amin, amax, bmin, bmax;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         ax_ff[i] <= me.cx[i] * ux;
         ay_ff[i] <= me.cy[i] * uy;
         ax_ff[i+4] <= ob_in.cx[i] * ux;
         ay_ff[i+4] <= ob_in.cy[i] * uy;
      end
      va_ff <= valid_in;
      ha_ff <= hit_in;
      ob_a_ff <= ob_in;
      valid_out <= va_ff;
      hit_out <= ha_ff && (amax >= bmin) && (bmax >= amin);
      ob_out <= ob_a_ff;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) p[i] = ax_ff[i] + ay_ff[i];
      amin = p[0]; amax = p[0]; bmin = p[4]; bmax = p[4];
      for (int i = 1; i < 4; i++) begin
         if (p[i] < amin) amin = p[i];
         if (p[i] > amax) amax = p[i];
         if (p[i+4] < bmin) bmin = p[i+4];
         if (p[i+4] > bmax) bmax = p[i+4];
      end
   end
endmodule
`default_nettype wire

// ===== design/oriented_box_collision_check_core.sv =====
// oriented_box_collision_check_core: obstacle table plus oriented box overlap check
// depends on obb_pkg, obb_ram, obb_box_cell, obb_axis_cell
// clear and append: the accepting edge moves to S_SIMPLE, which registers the result and
// returns to idle; query: S_ME builds the vehicle box, S_MAP answers when off the map or
// the table is empty, otherwise S_SCAN streams the n stored obstacles through the 3 box-cell
// steps and four axis cells; busy covers the whole item and the receiver cannot stall
// synchronous reset empties the table and restores the register defaults
`default_nettype none
module oriented_box_collision_check_core
   import obb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [23:0] req_pos_x,
   input  wire logic [23:0] req_pos_y,
   input  wire logic [15:0] req_heading,
   output logic             rsp_valid,
   output logic             rsp_collision,
   output logic             rsp_off_map,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [22:0] csr_data
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SIMPLE = 3'd1, S_ME = 3'd2,
                          S_MAP = 3'd3, S_SCAN = 3'd4, S_DONE = 3'd5;
   localparam int Lat = 12; // ram, 3 box steps, 8 in the axis chain

   logic [15:0] len_ff, wid_ff;
   logic [11:0] margin_ff;
   logic [22:0] mapw_ff, maph_ff;
   logic [CountBits-1:0] count_ff;
   logic [2:0] state_ff;
   logic [4:0] timer_ff;
   logic [CountBits-1:0] issue_ff;
   logic [1:0] op_ff;
   logic [23:0] qx_ff, qy_ff;
   logic [15:0] qh_ff;
   logic hit_ff;
   logic stored_ff;
   logic [Lat-1:0] vpipe_ff;
   box_type me_ff, box_o;
   logic [16:0] half_len, half_wid;
   logic [SlotBits-1:0] rd_addr;
   logic [23:0] ram_x, ram_y;
   logic [15:0] ram_h;
   logic wr_en, box_go, in_me;
   logic accept;
   logic issue_go, rsp_go;
   logic [3:0] vc;
   logic [3:0] hc;
   box_type [3:0] obc;
   logic off;

   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign half_len = 17'(len_ff) + 17'({margin_ff, 1'b0});
   assign half_wid = 17'(wid_ff) + 17'({margin_ff, 1'b0});
   assign wr_en = accept && req_operation == OP_APPEND && count_ff < CountBits'(ObstacleSlots);
   assign rd_addr = issue_ff[SlotBits-1:0];
   assign in_me = state_ff == S_ME;
   assign box_go = in_me ? (timer_ff == 5'd0) : 1'b1;

   // obstacle table
   obb_ram #(.Width(24), .Depth(ObstacleSlots)) u_x (.clock, .wr_en,
      .wr_addr(count_ff[SlotBits-1:0]), .wr_data(req_pos_x), .rd_addr, .rd_data(ram_x));
   obb_ram #(.Width(24), .Depth(ObstacleSlots)) u_y (.clock, .wr_en,
      .wr_addr(count_ff[SlotBits-1:0]), .wr_data(req_pos_y), .rd_addr, .rd_data(ram_y));
   obb_ram #(.Width(16), .Depth(ObstacleSlots)) u_h (.clock, .wr_en,
      .wr_addr(count_ff[SlotBits-1:0]), .wr_data(req_heading), .rd_addr, .rd_data(ram_h));

   // shared box builder: vehicle first, then stored obstacles
   obb_box_cell u_box (.clock, .go(box_go),
      .pos_x(in_me ? qx_ff : ram_x), .pos_y(in_me ? qy_ff : ram_y),
      .yaw(in_me ? qh_ff : ram_h), .half_len, .half_wid, .box(box_o));

   // aabb reject feeds the first cell
   assign vc[0] = vpipe_ff[Lat-9];
   assign hc[0] = !(me_ff.mxx < box_o.mnx || box_o.mxx < me_ff.mnx ||
                    me_ff.mxy < box_o.mny || box_o.mxy < me_ff.mny);
   assign obc[0] = box_o;

   // chain of four axis cells: own c, own -s... others
   trig_type ux [4], uy [4];
   logic v_last, h_last;
   box_type ob_last;
   always_comb begin
      ux[0] = me_ff.c;  uy[0] = me_ff.s;
      ux[1] = -me_ff.s; uy[1] = me_ff.c;
      ux[2] = obc[2].c; uy[2] = obc[2].s;
      ux[3] = -obc[3].s; uy[3] = obc[3].c;
   end
   for (genvar k = 0; k < 4; k++) begin : g_cell
      logic vo, ho;
      box_type bo;
      obb_axis_cell u_cell (.clock, .valid_in(vc[k]), .hit_in(hc[k]), .me(me_ff),
         .ob_in(obc[k]), .ux(ux[k]), .uy(uy[k]), .valid_out(vo), .hit_out(ho), .ob_out(bo));
      if (k < 3) begin : g_link
         assign vc[k+1] = vo;
         assign hc[k+1] = ho;
         assign obc[k+1] = bo;
      end else begin : g_end
         assign v_last = vo;
         assign h_last = ho;
         assign ob_last = bo;
      end
   end

   // map bounds on the vehicle box
   assign off = me_ff.mnx < 0 || me_ff.mny < 0 ||
                me_ff.mxx > (coord_type'({1'b0, mapw_ff}) <<< 15) ||
                me_ff.mxy > (coord_type'({1'b0, maph_ff}) <<< 15);

   // issue and result strobes
   assign issue_go = state_ff == S_SCAN && issue_ff < count_ff;
   assign rsp_go = (state_ff == S_MAP && (off || count_ff == '0)) ||
                   !(state_ff inside {S_IDLE, S_ME, S_MAP, S_SCAN});

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 16'd4608; wid_ff <= 16'd1843; margin_ff <= 12'd205;
         mapw_ff <= 23'd51200; maph_ff <= 23'd51200;
         count_ff <= '0; state_ff <= S_IDLE; rsp_valid <= 1'b0;
         vpipe_ff <= '0; timer_ff <= '0; issue_ff <= '0; hit_ff <= 1'b0;
      end else begin
         rsp_valid <= rsp_go;
         vpipe_ff <= {vpipe_ff[Lat-2:0], issue_go};
         if (csr_write) begin
            case (csr_index)
               CSR_LENGTH: len_ff <= csr_data[15:0];
               CSR_WIDTH: wid_ff <= csr_data[15:0];
               CSR_MARGIN: margin_ff <= csr_data[11:0];
               CSR_MAP_W: mapw_ff <= csr_data;
               CSR_MAP_H: maph_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (accept) begin
               op_ff <= req_operation; qx_ff <= req_pos_x; qy_ff <= req_pos_y;
               qh_ff <= req_heading; timer_ff <= '0; issue_ff <= '0; hit_ff <= 1'b0;
               if (req_operation == OP_CLEAR) begin
                  count_ff <= '0;
                  state_ff <= S_SIMPLE;
               end else if (req_operation == OP_APPEND) begin
                  if (wr_en) count_ff <= count_ff + 1'b1;
                  state_ff <= S_SIMPLE;
               end else begin
                  state_ff <= S_ME;
               end
            end
            S_SIMPLE: begin
               rsp_collision <= 1'b0; rsp_off_map <= 1'b0;
               rsp_status <= op_ff == OP_CLEAR ? ST_CLEARED :
                             (stored_ff ? ST_STORED : ST_FULL);
               state_ff <= S_IDLE;
            end
            S_ME: begin
               timer_ff <= timer_ff + 5'd1;
               if (timer_ff == 5'd3) begin
                  me_ff <= box_o;
                  state_ff <= S_MAP;
               end
            end
            S_MAP: begin
               if (off || count_ff == '0) begin
                  rsp_collision <= off; rsp_off_map <= off;
                  rsp_status <= ST_QUERY; state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (issue_go) issue_ff <= issue_ff + 1'b1;
               if (v_last && h_last) hit_ff <= 1'b1;
               if (issue_ff == count_ff && vpipe_ff == '0 && !v_last) state_ff <= S_DONE;
            end
            default: begin
               rsp_collision <= hit_ff; rsp_off_map <= 1'b0;
               rsp_status <= ST_QUERY; state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // append outcome kept for the result beat
   always_ff @(posedge clock) if (accept) stored_ff <= wr_en;

   // checks on sequencing, table count, result flags and obstacle bounds
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(ObstacleSlots)) else $error("table count overflow");
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
   a_off_coll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_off_map |-> rsp_collision) else $error("off map without collision");
   a_ob_bounds: assert property (@(posedge clock) disable iff (reset)
      v_last |-> ob_last.mnx <= ob_last.mxx && ob_last.mny <= ob_last.mxy)
      else $error("obstacle bounds out of order");
endmodule
`default_nettype wire

// ===== tb/oriented_box_collision_check_core_tb.sv =====
// testbench for oriented_box_collision_check_core: obstacle table ops and box queries
// checked against a behavioral box-overlap predictor; depends on obb_pkg and the core
`default_nettype none
module oriented_box_collision_check_core_tb
   import obb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic [23:0] req_pos_x = '0;
   logic [23:0] req_pos_y = '0;
   logic [15:0] req_heading = '0;
   logic rsp_valid, rsp_collision, rsp_off_map;
   logic [1:0] rsp_status;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [22:0] csr_data = '0;

   oriented_box_collision_check_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_heading(req_heading), .rsp_valid(rsp_valid), .rsp_collision(rsp_collision),
      .rsp_off_map(rsp_off_map), .rsp_status(rsp_status), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   typedef struct packed {
      logic collision;
      logic off_map;
      logic [1:0] status;
   } verdict_type;

   typedef struct {
      longint cx[4];
      longint cy[4];
      longint mnx, mny, mxx, mxy;
      longint ux[2];
      longint uy[2];
   } rect_type;

   // predictor copy of registers and table
   int unsigned car_len, car_wid, margin, lot_w, lot_h;
   logic [23:0] park_x[ObstacleSlots];
   logic [23:0] park_y[ObstacleSlots];
   logic [15:0] park_yaw[ObstacleSlots];
   int unsigned park_count;

   verdict_type pending_verdicts[$];
   int errors = 0;

   int sine_tab[33] = '{0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
      8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623, 14053, 14449,
      14811, 15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364, 16384};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("oriented_box_collision_check_core_tb NOT OK");
      $finish;
   end

   function automatic longint quarter_wave(int unsigned p);
      int unsigned idx, frac;
      if (p >= 16384) return 16384;
      idx = p >> 9;
      frac = p & 511;
      return sine_tab[idx] + (((sine_tab[idx + 1] - sine_tab[idx]) * frac + 256) >> 9);
   endfunction

   function automatic longint angle_sine(logic [15:0] h);
      int unsigned p;
      p = h[13:0];
      case (h[15:14])
         2'd0: return quarter_wave(p);
         2'd1: return quarter_wave(16384 - p);
         2'd2: return -quarter_wave(p);
         default: return -quarter_wave(16384 - p);
      endcase
   endfunction

   function automatic rect_type footprint(logic [23:0] px, logic [23:0] py,
                                          logic [15:0] yaw);
      rect_type r;
      longint hl, hw, s, c, x, y;
      longint lx[4], ly[4];
      hl = car_len + 2 * margin;
      hw = car_wid + 2 * margin;
      s = angle_sine(yaw);
      c = angle_sine(yaw + 16'd16384);
      lx = '{hl, hl, -hl, -hl};
      ly = '{hw, -hw, -hw, hw};
      for (int i = 0; i < 4; i++) begin
         x = longint'($signed(px)) * 32768 + lx[i] * c - ly[i] * s;
         y = longint'($signed(py)) * 32768 + lx[i] * s + ly[i] * c;
         r.cx[i] = x;
         r.cy[i] = y;
         if (i == 0 || x < r.mnx) r.mnx = x;
         if (i == 0 || x > r.mxx) r.mxx = x;
         if (i == 0 || y < r.mny) r.mny = y;
         if (i == 0 || y > r.mxy) r.mxy = y;
      end
      r.ux = '{c, -s};
      r.uy = '{s, c};
      return r;
   endfunction

   function automatic bit spans_meet(rect_type a, rect_type b, longint ux, longint uy);
      longint amin, amax, bmin, bmax, pa, pb;
      for (int i = 0; i < 4; i++) begin
         pa = a.cx[i] * ux + a.cy[i] * uy;
         pb = b.cx[i] * ux + b.cy[i] * uy;
         if (i == 0 || pa < amin) amin = pa;
         if (i == 0 || pa > amax) amax = pa;
         if (i == 0 || pb < bmin) bmin = pb;
         if (i == 0 || pb > bmax) bmax = pb;
      end
      return amax >= bmin && bmax >= amin;
   endfunction

   function automatic bit rects_touch(rect_type a, rect_type b);
      if (a.mxx < b.mnx || b.mxx < a.mnx || a.mxy < b.mny || b.mxy < a.mny) return 0;
      for (int k = 0; k < 2; k++) begin
         if (!spans_meet(a, b, a.ux[k], a.uy[k])) return 0;
         if (!spans_meet(a, b, b.ux[k], b.uy[k])) return 0;
      end
      return 1;
   endfunction

   // expected verdict for one command, updates the table copy
   function automatic verdict_type predict_verdict(logic [1:0] op, logic [23:0] px,
                                                   logic [23:0] py, logic [15:0] yaw);
      verdict_type v;
      rect_type me;
      v = '0;
      if (op == OP_CLEAR) begin
         park_count = 0;
         v.status = ST_CLEARED;
      end else if (op == OP_APPEND) begin
         if (park_count < ObstacleSlots) begin
            park_x[park_count] = px;
            park_y[park_count] = py;
            park_yaw[park_count] = yaw;
            park_count++;
            v.status = ST_STORED;
         end else begin
            v.status = ST_FULL;
         end
      end else begin
         me = footprint(px, py, yaw);
         if (me.mnx < 0 || me.mxx > longint'(lot_w) * 32768 ||
             me.mny < 0 || me.mxy > longint'(lot_h) * 32768) begin
            v.off_map = 1'b1;
            v.collision = 1'b1;
         end else begin
            for (int i = 0; i < park_count; i++) begin
               if (rects_touch(me, footprint(park_x[i], park_y[i], park_yaw[i]))) begin
                  v.collision = 1'b1;
                  break;
               end
            end
         end
         v.status = ST_QUERY;
      end
      return v;
   endfunction

   // result monitor
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result beat %b/%b/%0d", $time,
                     rsp_collision, rsp_off_map, rsp_status);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_collision !== want.collision) begin
               $display("%0t: collision expected %b actual %b", $time,
                        want.collision, rsp_collision);
               errors++;
            end
            if (rsp_off_map !== want.off_map) begin
               $display("%0t: off_map expected %b actual %b", $time,
                        want.off_map, rsp_off_map);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_results();
      while (pending_verdicts.size() != 0) @(negedge clock);
      idle_cycles(60);
   endtask

   task automatic write_reg(logic [2:0] idx, int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[22:0];
      case (idx)
         CSR_LENGTH: car_len = value & 16'hFFFF;
         CSR_WIDTH: car_wid = value & 16'hFFFF;
         CSR_MARGIN: margin = value & 12'hFFF;
         CSR_MAP_W: lot_w = value & 23'h7FFFFF;
         default: lot_h = value & 23'h7FFFFF;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // send one command beat; wait until accepted
   task automatic send_command(logic [1:0] op, logic [23:0] px, logic [23:0] py,
                               logic [15:0] yaw, bit randomize_gap);
      verdict_type v;
      if (randomize_gap && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 16));
      req_operation <= op;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= yaw;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      v = predict_verdict(op, px, py, yaw);
      pending_verdicts.insert(pending_verdicts.size(), v);
      @(negedge clock);
      start <= 1'b0;
      @(negedge clock);
   endtask

   // random pose, mostly near the lot center, sometimes anywhere or near the low x edge
   task automatic random_pose(output logic [23:0] px, output logic [23:0] py,
                              output logic [15:0] yaw);
      case ($urandom_range(0, 9))
         0: begin
            px = 24'($urandom);
            py = 24'($urandom);
         end
         1: begin
            px = 24'($urandom_range(0, 4096));
            py = 24'($urandom_range(0, 51200));
         end
         default: begin
            px = 24'($urandom_range(0, 16384) + 17408);
            py = 24'($urandom_range(0, 16384) + 17408);
         end
      endcase
      yaw = 16'($urandom);
   endtask

   typedef struct {
      logic [1:0] op;
      logic [23:0] px, py;
      logic [15:0] yaw;
      bit typed;
      verdict_type want;
   } row_type;

   row_type directed_rows[$];

   initial begin
      logic [23:0] px, py;
      logic [15:0] yaw;
      logic [1:0] op;
      verdict_type got;
      int n;
      car_len = 4608; car_wid = 1843; margin = 205;
      lot_w = 51200; lot_h = 51200;
      park_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table: typed verdicts where obvious, else predictor
      directed_rows = '{
         '{OP_QUERY, 24'd25600, 24'd25600, 16'd0, 1, '{1'b0, 1'b0, ST_QUERY}},
         '{OP_QUERY, 24'h800000, 24'h800000, 16'd0, 1, '{1'b1, 1'b1, ST_QUERY}},
         '{OP_QUERY, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1, '{1'b1, 1'b1, ST_QUERY}},
         '{OP_QUERY, 24'd0, 24'd25600, 16'd0, 1, '{1'b1, 1'b1, ST_QUERY}},
         '{OP_APPEND, 24'd25600, 24'd25600, 16'd16384, 1, '{1'b0, 1'b0, ST_STORED}},
         '{OP_QUERY, 24'd25600, 24'd25600, 16'd0, 0, '{0, 0, 0}},
         '{OP_QUERY, 24'd25600, 24'd30000, 16'd32768, 0, '{0, 0, 0}},
         '{OP_QUERY, 24'd25600, 24'd40000, 16'd49152, 0, '{0, 0, 0}},
         '{2'd3, 24'd25600, 24'd25600, 16'd8192, 0, '{0, 0, 0}},
         '{OP_QUERY, 24'd4000, 24'd4000, 16'd65535, 0, '{0, 0, 0}},
         '{OP_APPEND, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1, '{1'b0, 1'b0, ST_STORED}},
         '{OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1, '{1'b0, 1'b0, ST_CLEARED}},
         '{OP_QUERY, 24'd25600, 24'd25600, 16'd16384, 1, '{1'b0, 1'b0, ST_QUERY}}
      };
      foreach (directed_rows[i]) begin
         send_command(directed_rows[i].op, directed_rows[i].px, directed_rows[i].py,
                      directed_rows[i].yaw, 0);
         if (directed_rows[i].typed) begin
            got = pending_verdicts[$];
            if (got !== directed_rows[i].want) begin
               $display("%0t: row %0d expected %b actual %b", $time, i,
                        directed_rows[i].want, got);
               errors++;
            end
         end
      end

      // fill the table past full, then query against all slots
      for (int i = 0; i < ObstacleSlots + 2; i++) begin
         random_pose(px, py, yaw);
         send_command(OP_APPEND, px, py, yaw, 0);
      end
      send_command(OP_QUERY, 24'd25600, 24'd25600, 16'd0, 0);
      send_command(OP_QUERY, 24'd1000, 24'd50000, 16'd12345, 0);
      // hold off until the block has drained
      drain_results();

      // random phases under several register settings
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: begin
               write_reg(CSR_LENGTH, 0); write_reg(CSR_WIDTH, 0); write_reg(CSR_MARGIN, 0);
               write_reg(CSR_MAP_W, 0); write_reg(CSR_MAP_H, 0);
            end
            1: begin
               write_reg(CSR_LENGTH, 65535); write_reg(CSR_WIDTH, 65535);
               write_reg(CSR_MARGIN, 4095);
               write_reg(CSR_MAP_W, 8388607); write_reg(CSR_MAP_H, 8388607);
            end
            2: begin
               write_reg(CSR_LENGTH, 4608); write_reg(CSR_WIDTH, 1843);
               write_reg(CSR_MARGIN, 205);
               write_reg(CSR_MAP_W, 51200); write_reg(CSR_MAP_H, 51200);
            end
            default: begin
               write_reg(CSR_LENGTH, $urandom_range(0, 65535));
               write_reg(CSR_WIDTH, $urandom_range(0, 65535));
               write_reg(CSR_MARGIN, $urandom_range(0, 4095));
               write_reg(CSR_MAP_W, $urandom_range(30000, 8388607));
               write_reg(CSR_MAP_H, $urandom_range(30000, 8388607));
            end
         endcase
         n = 0;
         while (n < 180) begin
            random_pose(px, py, yaw);
            case ($urandom_range(0, 19))
               0: op = OP_CLEAR;
               1, 2, 3, 4, 5, 6: op = OP_APPEND;
               7: op = 2'd3;
               default: op = OP_QUERY;
            endcase
            send_command(op, px, py, yaw, 1);
            n++;
         end
      end

      drain_results();
      if (errors == 0) begin
         $display("oriented_box_collision_check_core_tb OK");
      end else begin
         $display("oriented_box_collision_check_core_tb NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
